// ===== design/integer_to_ascii_formatter_defines.svh =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter assertion macros
// shared property forms for the formatter checks
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ITOAF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itoaf check failed");

// next-cycle implication, disabled in reset
`define ITOAF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itoaf check failed");

`endif

// ===== design/itoaf_pkg.sv =====
// ----------------------------------------------------------------------------
// itoaf_pkg
// types, constants and microcode table of the integer to ascii formatter
// ----------------------------------------------------------------------------
`default_nettype none

package itoaf_pkg;

   localparam int VALUE_W    = 32;
   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = 8;
   localparam int DIG_W      = DEC_DIGITS * 4;
   localparam int CNT_W      = 4;
   localparam int IT_W       = 5;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] HEX_GAP    = 8'd7;
   localparam logic [3:0] NIB_NINE   = 4'd9;
   localparam logic [3:0] NIB_FIVE   = 4'd5;
   localparam logic [3:0] NIB_THREE  = 4'd3;

   localparam logic CMD_DEC = 1'b0;
   localparam logic CMD_HEX = 1'b1;

   typedef logic [2:0] step_type;

   localparam step_type STEP_WAIT     = 3'd0;
   localparam step_type STEP_DISPATCH = 3'd1;
   localparam step_type STEP_DABBLE   = 3'd2;
   localparam step_type STEP_SKIP     = 3'd3;
   localparam step_type STEP_SIGN     = 3'd4;
   localparam step_type STEP_EMIT     = 3'd5;
   localparam step_type STEP_DONE     = 3'd6;

   typedef enum logic [2:0] {
      OP_NOP    = 3'd0,
      OP_LOAD   = 3'd1,
      OP_DABBLE = 3'd2,
      OP_SKIP   = 3'd3,
      OP_SIGN   = 3'd4,
      OP_EMIT   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      HOLD_NONE = 2'd0,
      HOLD_REQ  = 2'd1,
      HOLD_OUT  = 2'd2
   } hold_type;

   typedef enum logic [2:0] {
      JMP_NEVER     = 3'd0,
      JMP_ALWAYS    = 3'd1,
      JMP_HEX       = 3'd2,
      JMP_IT_MORE   = 3'd3,
      JMP_SKIP_MORE = 3'd4,
      JMP_CHAR_MORE = 3'd5
   } jump_type;

   typedef struct packed {
      op_type   op;
      hold_type hold;
      jump_type jump;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_xfer;
      logic out_free;
      logic hex;
      logic it_more;
      logic skip_more;
      logic char_more;
   } status_type;

   function automatic ctrl_word_type microcode(input step_type step);
      ctrl_word_type cw;
      cw = '{op: OP_NOP, hold: HOLD_NONE, jump: JMP_ALWAYS, target: STEP_WAIT};
      case (step)
         STEP_WAIT: begin
            cw = '{op: OP_LOAD, hold: HOLD_REQ, jump: JMP_NEVER, target: STEP_WAIT};
         end
         STEP_DISPATCH: begin
            cw = '{op: OP_NOP, hold: HOLD_NONE, jump: JMP_HEX, target: STEP_SKIP};
         end
         STEP_DABBLE: begin
            cw = '{op: OP_DABBLE, hold: HOLD_NONE, jump: JMP_IT_MORE,
                   target: STEP_DABBLE};
         end
         STEP_SKIP: begin
            cw = '{op: OP_SKIP, hold: HOLD_NONE, jump: JMP_SKIP_MORE,
                   target: STEP_SKIP};
         end
         STEP_SIGN: begin
            cw = '{op: OP_SIGN, hold: HOLD_OUT, jump: JMP_NEVER, target: STEP_WAIT};
         end
         STEP_EMIT: begin
            cw = '{op: OP_EMIT, hold: HOLD_OUT, jump: JMP_CHAR_MORE,
                   target: STEP_EMIT};
         end
         STEP_DONE: begin
            cw = '{op: OP_NOP, hold: HOLD_NONE, jump: JMP_ALWAYS, target: STEP_WAIT};
         end
         default: begin
            cw = '{op: OP_NOP, hold: HOLD_NONE, jump: JMP_ALWAYS, target: STEP_WAIT};
         end
      endcase
      return cw;
   endfunction

   function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
      logic [7:0] c;
      c = {4'h0, nib} + CHAR_ZERO;
      if (nib > NIB_NINE) begin
         c = c + HEX_GAP;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// prints a 32-bit value as signed decimal or uppercase hex ascii text
// ----------------------------------------------------------------------------
// One value is taken at a time and printed one character per rsp transfer,
// most significant first, no leading zeros, tlast on the final character.
// Decimal mode works through these steps: one to take the value, one dispatch
// step, 32 steps of the bit-serial shift-add-3 converter, one step per skipped
// leading zero, one sign step, one step per character, and one closing step;
// the skipped zeros and characters together cover every digit position. Hex
// mode skips the converter, its skipped zeros and characters likewise covering
// every hex digit. A character that waits in the output register holds the
// sign step or a due character step until rsp_tready takes it. The next
// value is taken once the last character sits in the output register.
`default_nettype none

`include "integer_to_ascii_formatter_defines.svh"

module integer_to_ascii_formatter (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire         req_tuser,   // [0] command: 0 signed decimal, 1 hex
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] character
   output logic        rsp_tlast
);

   itoaf_pkg::ctrl_word_type cw;
   itoaf_pkg::status_type    status;
   logic                     req_xfer;

   assign req_tready = (cw.hold == itoaf_pkg::HOLD_REQ);
   assign req_xfer   = req_tvalid & req_tready;

   itoaf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   itoaf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cw          (cw),
      .req_xfer    (req_xfer),
      .req_command (req_tuser),
      .req_value   (req_tdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .status      (status)
   );

   `ITOAF_ASSERT_NEXT(a_busy_after_take, clock, reset, req_xfer, !req_tready)
   `ITOAF_ASSERT_NOW(a_char_legal, clock, reset, rsp_tvalid,
      (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
      (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h46) ||
      (rsp_tdata == itoaf_pkg::CHAR_MINUS))
   `ITOAF_ASSERT_NOW(a_minus_not_last, clock, reset,
      rsp_tvalid && (rsp_tdata == itoaf_pkg::CHAR_MINUS), !rsp_tlast)

endmodule

`default_nettype wire

// ===== design/itoaf_seq.sv =====
// ----------------------------------------------------------------------------
// itoaf_seq
// step counter and microcode lookup with hold and conditional jump
// ----------------------------------------------------------------------------
`default_nettype none

module itoaf_seq (
   input  wire                       clock,
   input  wire                       reset,
   input  itoaf_pkg::status_type     status,
   output itoaf_pkg::ctrl_word_type  cw
);

   itoaf_pkg::step_type pc_ff;
   itoaf_pkg::step_type pc_in;
   logic                done;
   logic                take;

   assign cw = itoaf_pkg::microcode(pc_ff);

   always_comb begin
      case (cw.hold)
         itoaf_pkg::HOLD_NONE: done = 1'b1;
         itoaf_pkg::HOLD_REQ:  done = status.req_xfer;
         itoaf_pkg::HOLD_OUT:  done = status.out_free;
         default:              done = 1'b1;
      endcase
   end

   always_comb begin
      case (cw.jump)
         itoaf_pkg::JMP_NEVER:     take = 1'b0;
         itoaf_pkg::JMP_ALWAYS:    take = 1'b1;
         itoaf_pkg::JMP_HEX:       take = status.hex;
         itoaf_pkg::JMP_IT_MORE:   take = status.it_more;
         itoaf_pkg::JMP_SKIP_MORE: take = status.skip_more;
         itoaf_pkg::JMP_CHAR_MORE: take = status.char_more;
         default:                  take = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (done) begin
         pc_in = take ? cw.target : pc_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= itoaf_pkg::STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/itoaf_dp.sv =====
// ----------------------------------------------------------------------------
// itoaf_dp
// magnitude, digit shift register, shift-add-3 converter and output register
// ----------------------------------------------------------------------------
`default_nettype none

module itoaf_dp (
   input  wire                                 clock,
   input  wire                                 reset,
   input  itoaf_pkg::ctrl_word_type            cw,
   input  wire                                 req_xfer,
   input  wire                                 req_command,
   input  wire [itoaf_pkg::VALUE_W-1:0]        req_value,
   input  wire                                 rsp_tready,
   output logic                                rsp_tvalid,
   output logic [7:0]                          rsp_tdata,
   output logic                                rsp_tlast,
   output itoaf_pkg::status_type               status
);

   logic [itoaf_pkg::VALUE_W-1:0] mag_ff, mag_in;
   logic [itoaf_pkg::DIG_W-1:0]   dig_ff, dig_in;
   logic [itoaf_pkg::DIG_W-1:0]   adj;
   logic [itoaf_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [itoaf_pkg::IT_W-1:0]    it_ff, it_in;
   logic                          neg_ff, neg_in;
   logic                          hex_ff, hex_in;
   logic                          ov_ff, ov_in;
   logic [7:0]                    od_ff, od_in;
   logic                          ol_ff, ol_in;
   logic                          out_free;
   logic                          is_neg;
   logic [3:0]                    top_nib;

   assign out_free = ~ov_ff | rsp_tready;
   assign top_nib  = dig_ff[itoaf_pkg::DIG_W-1 -: 4];
   assign is_neg   = (req_command == itoaf_pkg::CMD_DEC) & req_value[itoaf_pkg::VALUE_W-1];

   assign status.req_xfer  = req_xfer;
   assign status.out_free  = out_free;
   assign status.hex       = hex_ff;
   assign status.it_more   = (it_ff != '0);
   assign status.skip_more = (top_nib == 4'h0) && (cnt_ff != itoaf_pkg::CNT_W'(1));
   assign status.char_more = (cnt_ff != itoaf_pkg::CNT_W'(1));

   // add three to every bcd digit of five or more
   always_comb begin
      for (int i = 0; i < itoaf_pkg::DEC_DIGITS; i++) begin
         adj[i*4 +: 4] = (dig_ff[i*4 +: 4] >= itoaf_pkg::NIB_FIVE) ?
                         dig_ff[i*4 +: 4] + itoaf_pkg::NIB_THREE : dig_ff[i*4 +: 4];
      end
   end

   always_comb begin
      mag_in = mag_ff;
      dig_in = dig_ff;
      cnt_in = cnt_ff;
      it_in  = it_ff;
      neg_in = neg_ff;
      hex_in = hex_ff;
      ov_in  = ov_ff & ~rsp_tready;
      od_in  = od_ff;
      ol_in  = ol_ff;
      case (cw.op)
         itoaf_pkg::OP_LOAD: begin
            if (req_xfer) begin
               hex_in = req_command;
               neg_in = is_neg;
               mag_in = is_neg ? (~req_value) + itoaf_pkg::VALUE_W'(1) : req_value;
               it_in  = itoaf_pkg::IT_W'(itoaf_pkg::VALUE_W - 1);
               if (req_command == itoaf_pkg::CMD_HEX) begin
                  dig_in = {req_value, {(itoaf_pkg::DIG_W - itoaf_pkg::VALUE_W){1'b0}}};
                  cnt_in = itoaf_pkg::CNT_W'(itoaf_pkg::HEX_DIGITS);
               end else begin
                  dig_in = '0;
                  cnt_in = itoaf_pkg::CNT_W'(itoaf_pkg::DEC_DIGITS);
               end
            end
         end
         itoaf_pkg::OP_DABBLE: begin
            dig_in = {adj[itoaf_pkg::DIG_W-2:0], mag_ff[itoaf_pkg::VALUE_W-1]};
            mag_in = {mag_ff[itoaf_pkg::VALUE_W-2:0], 1'b0};
            it_in  = it_ff - itoaf_pkg::IT_W'(1);
         end
         itoaf_pkg::OP_SKIP: begin
            if (status.skip_more) begin
               dig_in = {dig_ff[itoaf_pkg::DIG_W-5:0], 4'h0};
               cnt_in = cnt_ff - itoaf_pkg::CNT_W'(1);
            end
         end
         itoaf_pkg::OP_SIGN: begin
            if (out_free && neg_ff) begin
               ov_in = 1'b1;
               od_in = itoaf_pkg::CHAR_MINUS;
               ol_in = 1'b0;
            end
         end
         itoaf_pkg::OP_EMIT: begin
            if (out_free) begin
               ov_in  = 1'b1;
               od_in  = itoaf_pkg::nib_to_ascii(top_nib);
               ol_in  = (cnt_ff == itoaf_pkg::CNT_W'(1));
               dig_in = {dig_ff[itoaf_pkg::DIG_W-5:0], 4'h0};
               cnt_in = cnt_ff - itoaf_pkg::CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      dig_ff <= dig_in;
      cnt_ff <= cnt_in;
      it_ff  <= it_in;
      neg_ff <= neg_in;
      hex_ff <= hex_in;
      od_ff  <= od_in;
      ol_ff  <= ol_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = ol_ff;

endmodule

`default_nettype wire
